// File: sv/tcw_pkg.sv
// Shared types and constants for the text console writer.
package tcw_pkg;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] SPACE_CODE   = 8'd32;
    localparam logic [7:0] ATTR_RESET   = 8'd15;

    // Widest saturated column and row the parameter ranges allow
    localparam int COL_BITS = 8;
    localparam int ROW_BITS = 7;

    typedef enum logic [1:0] {
        MODE_PUT   = 2'd0,
        MODE_READ  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    // Classified item handed from the front end to the engine
    typedef struct packed {
        mode_t                mode;
        logic                 newline;
        logic                 at_cursor;
        logic [7:0]           char_code;
        logic [7:0]           attr;
        logic [COL_BITS-1:0]  col;
        logic [ROW_BITS-1:0]  row;
    } cmd_t;

    // Queue status seen by the front end
    typedef struct packed {
        logic full;
        logic init_busy;
    } front_status_t;

endpackage

// File: sv/tcw_ram.sv
// Generic simple dual-port RAM with registered read.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/tcw_queue.sv
// Two-entry command queue between the front end and the engine.
module tcw_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  tcw_pkg::cmd_t din,
    input  logic          pop,
    output tcw_pkg::cmd_t dout,
    output logic          full,
    output logic          empty
);

    tcw_pkg::cmd_t slot_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

    assign dout  = slot_reg[rd_ptr_reg];
    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);

endmodule

// File: sv/tcw_front.sv
// Front end: accepts input items, saturates col/row, resolves attribute, queues commands.
module tcw_front #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [7:0]            cfg_wr_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,
    input  logic [1:0]            s_axis_tuser,
    input  tcw_pkg::front_status_t status,
    output logic                  push,
    output tcw_pkg::cmd_t         cmd
);

    logic [7:0] default_attr_reg;
    logic [7:0] char_code;
    logic [7:0] attribute;
    logic [6:0] col;
    logic [4:0] row;
    logic [8:0] col_ext;
    logic [7:0] row_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_attr_reg <= tcw_pkg::ATTR_RESET;
        end else if (cfg_wr_en) begin
            default_attr_reg <= cfg_wr_data;
        end
    end

    assign char_code = s_axis_tdata[7:0];
    assign attribute = s_axis_tdata[15:8];
    assign col       = s_axis_tdata[23:17];
    assign row       = s_axis_tdata[28:24];
    assign col_ext   = {2'b00, col};
    assign row_ext   = {3'b000, row};

    assign s_axis_tready = !status.full && !status.init_busy;
    assign push          = s_axis_tvalid && s_axis_tready;

    always_comb begin
        cmd           = '0;
        cmd.mode      = tcw_pkg::mode_t'(s_axis_tuser);
        cmd.newline   = (char_code == tcw_pkg::NEWLINE_CODE);
        cmd.at_cursor = s_axis_tdata[16];
        cmd.char_code = char_code;
        // clear always uses the default attribute
        if (attribute == 8'd0 || cmd.mode == tcw_pkg::MODE_CLEAR) begin
            cmd.attr = default_attr_reg;
        end else begin
            cmd.attr = attribute;
        end
        if (col_ext >= 9'(COLUMNS)) begin
            cmd.col = tcw_pkg::COL_BITS'(COLUMNS - 1);
        end else begin
            cmd.col = tcw_pkg::COL_BITS'(col_ext);
        end
        if (row_ext >= 8'(ROWS)) begin
            cmd.row = tcw_pkg::ROW_BITS'(ROWS - 1);
        end else begin
            cmd.row = tcw_pkg::ROW_BITS'(row_ext);
        end
    end

endmodule

// File: sv/tcw_engine.sv
// Engine: executes commands on the screen store, scrolls, clears and issues results.
module tcw_engine #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_empty,
    input  tcw_pkg::cmd_t q_cmd,
    output logic          q_pop,
    output logic          init_busy,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [31:0]   m_axis_tdata
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CALC,
        ST_EXEC,
        ST_RD_WAIT,
        ST_COPY,
        ST_COPY_LAST,
        ST_FILL,
        ST_RESULT
    } state_t;

    state_t         state_reg;
    tcw_pkg::mode_t mode_reg;
    logic           newline_reg;
    logic [7:0]     char_reg;
    logic [7:0]     attr_reg;
    logic [RW-1:0]  tgt_row_reg;
    logic [CW-1:0]  tgt_col_reg;
    logic [AW-1:0]  addr_reg;
    logic [RW-1:0]  cur_row_reg;
    logic [CW-1:0]  cur_col_reg;
    logic [AW-1:0]  cur_idx_reg;
    logic [AW-1:0]  copy_rd_reg;
    logic           copy_wr_vld_reg;
    logic [AW-1:0]  copy_wr_addr_reg;
    logic [AW-1:0]  fill_addr_reg;
    logic [15:0]    fill_val_reg;
    logic           scrolled_reg;
    logic [7:0]     rd_char_reg;
    logic [7:0]     rd_attr_reg;
    logic           m_valid_reg;
    logic [31:0]    m_data_reg;

    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [15:0]    ram_wdata;
    logic           ram_re;
    logic [AW-1:0]  ram_raddr;
    logic [15:0]    ram_rdata;
    logic           row_end;
    logic           last_row;

    tcw_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_screen (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign row_end  = (tgt_col_reg == CW'(COLUMNS - 1));
    assign last_row = (tgt_row_reg == RW'(ROWS - 1));

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = {attr_reg, char_reg};
        ram_re    = 1'b0;
        ram_raddr = addr_reg;
        if (copy_wr_vld_reg) begin
            ram_we    = 1'b1;
            ram_waddr = copy_wr_addr_reg;
            ram_wdata = ram_rdata;
        end else if (state_reg == ST_INIT || state_reg == ST_FILL) begin
            ram_we    = 1'b1;
            ram_waddr = fill_addr_reg;
            ram_wdata = fill_val_reg;
        end else if (state_reg == ST_EXEC && mode_reg == tcw_pkg::MODE_PUT
                     && !newline_reg) begin
            ram_we = 1'b1;
        end
        if (state_reg == ST_COPY) begin
            ram_re    = 1'b1;
            ram_raddr = copy_rd_reg;
        end else if (state_reg == ST_EXEC && mode_reg == tcw_pkg::MODE_READ) begin
            ram_re = 1'b1;
        end
    end

    assign q_pop         = (state_reg == ST_IDLE) && !q_empty;
    assign init_busy     = (state_reg == ST_INIT);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_INIT;
            fill_addr_reg   <= '0;
            fill_val_reg    <= '0;
            copy_wr_vld_reg <= 1'b0;
            cur_row_reg     <= '0;
            cur_col_reg     <= '0;
            cur_idx_reg     <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            // the result state reloads the output register itself
            if (m_valid_reg && m_axis_tready && state_reg != ST_RESULT) begin
                m_valid_reg <= 1'b0;
            end
            copy_wr_vld_reg <= (state_reg == ST_COPY);
            case (state_reg)
                ST_INIT: begin
                    fill_addr_reg <= fill_addr_reg + 1'b1;
                    if (fill_addr_reg == AW'(CELLS - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (!q_empty) begin
                        mode_reg     <= q_cmd.mode;
                        newline_reg  <= q_cmd.newline;
                        char_reg     <= q_cmd.char_code;
                        attr_reg     <= q_cmd.attr;
                        scrolled_reg <= 1'b0;
                        rd_char_reg  <= 8'd0;
                        rd_attr_reg  <= 8'd0;
                        if (q_cmd.mode == tcw_pkg::MODE_PUT && q_cmd.at_cursor) begin
                            tgt_row_reg <= cur_row_reg;
                            tgt_col_reg <= cur_col_reg;
                        end else begin
                            tgt_row_reg <= RW'(q_cmd.row);
                            tgt_col_reg <= CW'(q_cmd.col);
                        end
                        // newline targets the last column of its row
                        if (q_cmd.mode == tcw_pkg::MODE_PUT && q_cmd.newline) begin
                            tgt_col_reg <= CW'(COLUMNS - 1);
                        end
                        case (q_cmd.mode)
                            tcw_pkg::MODE_PUT,
                            tcw_pkg::MODE_READ: begin
                                state_reg <= ST_CALC;
                            end
                            tcw_pkg::MODE_CLEAR: begin
                                fill_addr_reg <= '0;
                                fill_val_reg  <= {q_cmd.attr, tcw_pkg::SPACE_CODE};
                                cur_row_reg   <= '0;
                                cur_col_reg   <= '0;
                                cur_idx_reg   <= '0;
                                state_reg     <= ST_FILL;
                            end
                            default: begin
                                state_reg <= ST_RESULT;
                            end
                        endcase
                    end
                end
                ST_CALC: begin
                    addr_reg  <= AW'(tgt_row_reg) * AW'(COLUMNS) + AW'(tgt_col_reg);
                    state_reg <= ST_EXEC;
                end
                ST_EXEC: begin
                    if (mode_reg == tcw_pkg::MODE_READ) begin
                        state_reg <= ST_RD_WAIT;
                    end else begin
                        // advance the cursor past the target
                        if (!row_end) begin
                            cur_row_reg <= tgt_row_reg;
                            cur_col_reg <= tgt_col_reg + 1'b1;
                            cur_idx_reg <= addr_reg + 1'b1;
                            state_reg   <= ST_RESULT;
                        end else if (!last_row) begin
                            cur_row_reg <= tgt_row_reg + 1'b1;
                            cur_col_reg <= '0;
                            cur_idx_reg <= addr_reg + 1'b1;
                            state_reg   <= ST_RESULT;
                        end else begin
                            cur_row_reg  <= RW'(ROWS - 1);
                            cur_col_reg  <= '0;
                            cur_idx_reg  <= AW'(CELLS - COLUMNS);
                            scrolled_reg <= 1'b1;
                            copy_rd_reg  <= AW'(COLUMNS);
                            state_reg    <= ST_COPY;
                        end
                    end
                end
                ST_RD_WAIT: begin
                    rd_char_reg <= ram_rdata[7:0];
                    rd_attr_reg <= ram_rdata[15:8];
                    state_reg   <= ST_RESULT;
                end
                ST_COPY: begin
                    // read one row ahead, write it back in the following cycle
                    copy_wr_addr_reg <= copy_rd_reg - AW'(COLUMNS);
                    copy_rd_reg      <= copy_rd_reg + 1'b1;
                    if (copy_rd_reg == AW'(CELLS - 1)) begin
                        state_reg <= ST_COPY_LAST;
                    end
                end
                ST_COPY_LAST: begin
                    fill_addr_reg <= AW'(CELLS - COLUMNS);
                    fill_val_reg  <= '0;
                    state_reg     <= ST_FILL;
                end
                ST_FILL: begin
                    fill_addr_reg <= fill_addr_reg + 1'b1;
                    if (fill_addr_reg == AW'(CELLS - 1)) begin
                        state_reg <= ST_RESULT;
                    end
                end
                ST_RESULT: begin
                    if (!m_valid_reg || m_axis_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {4'b0000, rd_attr_reg, rd_char_reg,
                                        scrolled_reg, 11'(cur_idx_reg)};
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: sv/text_console_writer.sv
// Text console writer: 80x25-style character-cell screen with put, read, clear and scroll.
// The engine's sequencer handles one command at a time; the front end keeps accepting items
// into the two-entry queue while it works, until that queue is full. Clear and scroll take
// one RAM cell per cycle across the whole store.
// Reset (aresetn low, synchronous): cursor to 0, default attribute 15, then a clearing pass
// writes zeros to every cell while s_axis_tready stays low.
module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // char_code[7:0], attribute[15:8], at_cursor[16], col[23:17], row[28:24], zero[31:29]
    input  logic [31:0] s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // cursor_cell[10:0], scrolled[11], read_char[19:12], read_attr[27:20], zero[31:28]
    output logic [31:0] m_axis_tdata
);

    tcw_pkg::cmd_t          push_cmd;
    tcw_pkg::cmd_t          head_cmd;
    tcw_pkg::front_status_t front_status;
    logic                   push;
    logic                   pop;
    logic                   q_full;
    logic                   q_empty;
    logic                   init_busy;

    assign front_status.full      = q_full;
    assign front_status.init_busy = init_busy;

    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .status        (front_status),
        .push          (push),
        .cmd           (push_cmd)
    );

    tcw_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .din     (push_cmd),
        .pop     (pop),
        .dout    (head_cmd),
        .full    (q_full),
        .empty   (q_empty)
    );

    tcw_engine #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_engine (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (q_empty),
        .q_cmd         (head_cmd),
        .q_pop         (pop),
        .init_busy     (init_busy),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// File: sv/tcw_checker.sv
// Port-level assertions for the text console writer, bound to the top level.
module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    localparam int CELLS = COLUMNS * ROWS;

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (CELLS > 2047) || (m_axis_tdata[10:0] < 11'(CELLS)))
        else $error("cursor beyond the screen");

    a_scroll_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[11] |->
            m_axis_tdata[10:0] == 11'((ROWS - 1) * COLUMNS))
        else $error("scroll left cursor off the bottom row start");

    a_read_no_scroll: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[27:12] != 16'd0 |-> !m_axis_tdata[11])
        else $error("read data alongside a scroll");

    // reset starts the clearing pass with both channels closed
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid && !s_axis_tready)
        else $error("channels open right after reset");

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: bench/testbench.sv
// Self-checking bench for the text console writer: stream stimulus, screen predictor, checks.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    typedef struct packed {
        tcw_pkg::mode_t mode;
        logic [7:0]     char_code;
        logic [7:0]     attr;
        logic           at_cursor;
        logic [6:0]     col;
        logic [4:0]     row;
    } console_item_t;

    typedef struct packed {
        logic [10:0] cursor_cell;
        logic        scrolled;
        logic [7:0]  read_char;
        logic [7:0]  read_attr;
    } console_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_wr_data = 8'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = 32'd0;
    logic [1:0]  s_axis_tuser = 2'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;

    text_console_writer #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #5 aclk = ~aclk;

    // Predicted screen state
    logic [15:0]     screen_mem [0:CELLS-1];
    int unsigned     cursor_pos;
    logic [7:0]      default_attr;

    console_item_t   pending_items [$];
    console_result_t expected_results [$];
    console_item_t   drive_item;
    console_item_t   seen_item;
    console_result_t want;

    int accepted_count = 0;
    int offered_count  = 0;
    int error_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int hold_served    = 0;
    int hold_left      = 0;

    task automatic report_mismatch(string what, int got, int exp_val);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, exp_val, $realtime);
        error_count++;
    endtask

    function automatic int unsigned cell_of(logic [6:0] col, logic [4:0] row);
        int unsigned c;
        int unsigned r;
        c = (col >= COLUMNS) ? COLUMNS - 1 : col;
        r = (row >= ROWS) ? ROWS - 1 : row;
        return r * COLUMNS + c;
    endfunction

    // Apply one item to the predicted screen and return its result
    function automatic console_result_t console_step(console_item_t it);
        console_result_t res;
        int unsigned     target;
        int unsigned     next_cell;
        logic [7:0]      attr;
        logic [15:0]     cell_word;
        res = '0;
        case (it.mode)
            tcw_pkg::MODE_PUT: begin
                attr = (it.attr == 8'd0) ? default_attr : it.attr;
                target = it.at_cursor ? cursor_pos : cell_of(it.col, it.row);
                if (target >= CELLS) target = CELLS - 1;
                if (it.char_code == tcw_pkg::NEWLINE_CODE)
                    target = (target / COLUMNS) * COLUMNS + COLUMNS - 1;
                else
                    screen_mem[target] = {attr, it.char_code};
                next_cell = target + 1;
                if (next_cell < CELLS) begin
                    cursor_pos = next_cell;
                end else begin
                    // shift every row up and blank the bottom one
                    for (int i = 0; i < CELLS - COLUMNS; i++)
                        screen_mem[i] = screen_mem[i + COLUMNS];
                    for (int i = CELLS - COLUMNS; i < CELLS; i++)
                        screen_mem[i] = 16'd0;
                    cursor_pos = next_cell - COLUMNS;
                    res.scrolled = 1'b1;
                end
            end
            tcw_pkg::MODE_READ: begin
                cell_word = screen_mem[cell_of(it.col, it.row)];
                res.read_char = cell_word[7:0];
                res.read_attr = cell_word[15:8];
            end
            tcw_pkg::MODE_CLEAR: begin
                for (int i = 0; i < CELLS; i++)
                    screen_mem[i] = {default_attr, tcw_pkg::SPACE_CODE};
                cursor_pos = 0;
            end
            default: ;
        endcase
        res.cursor_cell = cursor_pos[10:0];
        return res;
    endfunction

    // Monitor: track config writes, predict accepted items, check results
    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CELLS; i++) screen_mem[i] = 16'd0;
            cursor_pos   = 0;
            default_attr = tcw_pkg::ATTR_RESET;
        end else begin
            if (cfg_wr_en) default_attr = cfg_wr_data;
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result, cursor", m_axis_tdata[10:0], 0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_axis_tdata[10:0] !== want.cursor_cell)
                        report_mismatch("cursor_cell", m_axis_tdata[10:0], want.cursor_cell);
                    if (m_axis_tdata[11] !== want.scrolled)
                        report_mismatch("scrolled", m_axis_tdata[11], want.scrolled);
                    if (m_axis_tdata[19:12] !== want.read_char)
                        report_mismatch("read_char", m_axis_tdata[19:12], want.read_char);
                    if (m_axis_tdata[27:20] !== want.read_attr)
                        report_mismatch("read_attr", m_axis_tdata[27:20], want.read_attr);
                    if (m_axis_tdata[31:28] !== 4'd0)
                        report_mismatch("padding", m_axis_tdata[31:28], 0);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                seen_item.mode      = tcw_pkg::mode_t'(s_axis_tuser);
                seen_item.char_code = s_axis_tdata[7:0];
                seen_item.attr      = s_axis_tdata[15:8];
                seen_item.at_cursor = s_axis_tdata[16];
                seen_item.col       = s_axis_tdata[23:17];
                seen_item.row       = s_axis_tdata[28:24];
                expected_results.push_back(console_step(seen_item));
                accepted_count++;
            end
        end
    end

    // Driver: offer queued items, idle at random between them
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || accepted_count == offered_count) begin
            if (pending_items.size() == 0 || $urandom_range(99) < send_idle_pct) begin
                s_axis_tvalid <= 1'b0;
            end else begin
                drive_item = pending_items.pop_front();
                s_axis_tdata <= {3'b000, drive_item.row, drive_item.col, drive_item.at_cursor,
                                 drive_item.attr, drive_item.char_code};
                s_axis_tuser  <= drive_item.mode;
                s_axis_tvalid <= 1'b1;
                offered_count++;
            end
        end
    end

    // Receiver: random stalls, plus long hold-offs on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (hold_requests != hold_served) begin
            hold_served++;
            hold_left = 400;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic add_item(tcw_pkg::mode_t mode, logic [7:0] ch, logic [7:0] attr,
                            logic at_cur, logic [6:0] col, logic [4:0] row);
        console_item_t it;
        it.mode      = mode;
        it.char_code = ch;
        it.attr      = attr;
        it.at_cursor = at_cur;
        it.col       = col;
        it.row       = row;
        pending_items.push_back(it);
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || accepted_count != offered_count ||
               expected_results.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_default_attr(logic [7:0] value);
        repeat (8) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Mostly text runs at the cursor, with reads, clears and stray items mixed in
    task automatic send_text_batch(int count);
        int unsigned    pick;
        tcw_pkg::mode_t mode;
        logic [7:0]     ch;
        logic [7:0]     attr;
        logic           at_cur;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 68) mode = tcw_pkg::MODE_PUT;
            else if (pick < 90) mode = tcw_pkg::MODE_READ;
            else if (pick < 93) mode = tcw_pkg::MODE_CLEAR;
            else mode = tcw_pkg::MODE_NONE;
            ch     = ($urandom_range(99) < 15) ? tcw_pkg::NEWLINE_CODE
                                               : 8'($urandom_range(255));
            attr   = ($urandom_range(99) < 20) ? 8'd0 : 8'($urandom_range(255));
            at_cur = ($urandom_range(99) < 65);
            add_item(mode, ch, attr, at_cur, 7'($urandom_range(127)), 5'($urandom_range(31)));
        end
    endtask

    logic [7:0] attr_plan [8];

    initial begin
        attr_plan = '{8'd0, 8'd255, 8'($urandom_range(1, 254)), 8'd1,
                      8'd255, 8'd0, 8'($urandom_range(1, 254)), tcw_pkg::ATTR_RESET};
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: reset contents, default attribute, saturation, scroll, newline, clear
        add_item(tcw_pkg::MODE_READ,  8'd0,  8'd0,  1'b0, 7'd0,   5'd0);
        add_item(tcw_pkg::MODE_PUT,   8'h41, 8'd0,  1'b1, 7'd0,   5'd0);
        add_item(tcw_pkg::MODE_PUT,   8'hFF, 8'hFF, 1'b0, 7'd127, 5'd31);
        add_item(tcw_pkg::MODE_READ,  8'd0,  8'd0,  1'b0, 7'd127, 5'd31);
        add_item(tcw_pkg::MODE_READ,  8'd0,  8'd0,  1'b0, 7'd79,  5'd23);
        add_item(tcw_pkg::MODE_PUT,   tcw_pkg::NEWLINE_CODE, 8'h12, 1'b1, 7'd0, 5'd0);
        add_item(tcw_pkg::MODE_PUT,   8'd0,  8'd1,  1'b0, 7'd0,   5'd0);
        add_item(tcw_pkg::MODE_PUT,   tcw_pkg::NEWLINE_CODE, 8'h34, 1'b0, 7'd5, 5'd3);
        add_item(tcw_pkg::MODE_PUT,   8'h7F, 8'h80, 1'b1, 7'd0,   5'd0);
        add_item(tcw_pkg::MODE_READ,  8'hFF, 8'hFF, 1'b1, 7'd4,   5'd3);
        add_item(tcw_pkg::MODE_READ,  8'd0,  8'd0,  1'b0, 7'd0,   5'd4);
        add_item(tcw_pkg::MODE_NONE,  8'hFF, 8'hFF, 1'b1, 7'd127, 5'd31);
        add_item(tcw_pkg::MODE_PUT,   8'h80, 8'h7F, 1'b0, 7'd80,  5'd25);
        add_item(tcw_pkg::MODE_READ,  8'd0,  8'd0,  1'b0, 7'd80,  5'd25);
        add_item(tcw_pkg::MODE_PUT,   8'h55, 8'hAA, 1'b0, 7'd0,   5'd31);
        add_item(tcw_pkg::MODE_READ,  8'd0,  8'd0,  1'b0, 7'd0,   5'd24);
        add_item(tcw_pkg::MODE_CLEAR, 8'h5A, 8'hA5, 1'b1, 7'd42,  5'd7);
        add_item(tcw_pkg::MODE_READ,  8'd0,  8'd0,  1'b0, 7'd0,   5'd0);
        add_item(tcw_pkg::MODE_READ,  8'd0,  8'd0,  1'b0, 7'd127, 5'd0);
        add_item(tcw_pkg::MODE_PUT,   8'h20, 8'd0,  1'b1, 7'd0,   5'd0);
        add_item(tcw_pkg::MODE_PUT,   8'h43, 8'd0,  1'b0, 7'd79,  5'd24);
        add_item(tcw_pkg::MODE_READ,  8'd0,  8'd0,  1'b0, 7'd79,  5'd23);
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            for (int half = 0; half < 2; half++) begin
                write_default_attr(attr_plan[2 * phase + half]);
                // block fills up behind a long receiver hold-off
                if (half == 1 && (phase == 0 || phase == 3)) hold_requests++;
                send_text_batch(155);
                wait_drained();
            end
        end

        repeat (CELLS + 100) @(negedge aclk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("timeout waiting for results");
        $display("*** FAILED ***");
        $finish;
    end

endmodule
